// ----- rtl/epgu_pkg.sv -----
package epgu_pkg;

	localparam int VERT_COUNT_DEF = 1024;
	localparam int DIM_DEF = 2;

	localparam int VERT_W = 10;
	localparam int COORD_W = 32;
	localparam int GAMMA_W = 24;
	localparam int CLIP_W = 24;
	localparam int LR_W = 18;
	localparam int CNT_W = 4;
	localparam int REQ_W = 2;
	localparam int CI_W = 3;
	localparam int DIFF_W = 33;
	localparam int PROD_W = 66;
	localparam int DIV_NUM_W = 58;
	localparam int DIV_DEN_W = 33;
	localparam int GMAG_W = 29;
	localparam int STEP_W = 26;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [16:0] ONE_Q = 17'd65536;
	localparam logic [12:0] TENTH_Q = 13'd6554;

	localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

	localparam logic [1:0] REG_GAMMA = 2'd0;
	localparam logic [1:0] REG_CLIP = 2'd1;
	localparam logic [1:0] REG_LR = 2'd2;

	localparam logic [GAMMA_W-1:0] GAMMA_RST = 24'd458752;
	localparam logic [CLIP_W-1:0] CLIP_RST = 24'd327680;
	localparam logic [LR_W-1:0] LR_RST = 18'd65536;

	typedef enum logic [1:0] {
		KIND_UPD,
		KIND_WR,
		KIND_RD,
		KIND_NOP
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_WR,
		ST_RD,
		ST_RD_DATA,
		ST_LD_S,
		ST_LD_T,
		ST_LD_D,
		ST_SQ,
		ST_ACC,
		ST_DIV1_GO,
		ST_DIV1,
		ST_DIV2_GO,
		ST_DIV2,
		ST_GM1,
		ST_GM2,
		ST_GM3,
		ST_GM4,
		ST_CM_RD,
		ST_CM_WR,
		ST_RESULT
	} bst_t;

	typedef struct packed {
		logic start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

// ----- rtl/embedding_pair_gradient_update.sv -----
// Vertex embedding SGD engine: keeps VERT_COUNT x DIM signed Q16.16 coordinates in one
// single-port memory and serves write, read and update transactions, one result each.
// A front stage reduces vertex numbers and classifies each transaction into a two-entry
// queue; a back sequencer does one transaction at a time, and an invalid one also gets a
// result. An update does one division through the bit-serial divider for a positive pair
// and a second one for a negative sample, and with end_of_group it adds the accumulated
// steps to the source coordinates through the one memory port. Registers: gamma at 0x0,
// grad_clip at 0x4, learn_rate at 0x8; the port has no wait states.
module embedding_pair_gradient_update #(
	parameter int VERT_COUNT = epgu_pkg::VERT_COUNT_DEF,
	parameter int DIM = epgu_pkg::DIM_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [epgu_pkg::PADDR_W-1:0] paddr,
	input logic [epgu_pkg::PDATA_W-1:0] pwdata,
	output logic [epgu_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic [epgu_pkg::REQ_W-1:0] req_type,
	input logic [epgu_pkg::VERT_W-1:0] source_vertex,
	input logic [epgu_pkg::VERT_W-1:0] target_vertex,
	input logic is_positive,
	input logic end_of_group,
	input logic [epgu_pkg::CI_W-1:0] coord_index,
	input logic signed [epgu_pkg::COORD_W-1:0] coord_value,
	output logic out_valid,
	input logic out_stall,
	output logic signed [epgu_pkg::COORD_W-1:0] coord_out,
	output logic [epgu_pkg::COORD_W-1:0] dist_sq,
	output logic [epgu_pkg::CNT_W-1:0] clipped_count
);
	import epgu_pkg::*;

	localparam int VW = $clog2(VERT_COUNT);
	localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;

	logic [GAMMA_W-1:0] gamma_q;
	logic [CLIP_W-1:0] clip_q;
	logic [LR_W-1:0] lr_q;
	logic wr_en;

	logic q_valid;
	logic q_pop;
	kind_t q_kind;
	logic [VW-1:0] q_src;
	logic [VW-1:0] q_tgt;
	logic q_positive;
	logic q_eog;
	logic [IW-1:0] q_ci;
	logic [COORD_W-1:0] q_value;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RST;
			clip_q <= CLIP_RST;
			lr_q <= LR_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_GAMMA: gamma_q <= pwdata[GAMMA_W-1:0];
				REG_CLIP: clip_q <= pwdata[CLIP_W-1:0];
				REG_LR: lr_q <= pwdata[LR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_GAMMA: prdata = PDATA_W'(gamma_q);
			REG_CLIP: prdata = PDATA_W'(clip_q);
			REG_LR: prdata = PDATA_W'(lr_q);
			default: prdata = '0;
		endcase
	end

	epgu_front #(
		.VERT_COUNT(VERT_COUNT),
		.DIM(DIM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.source_vertex(source_vertex),
		.target_vertex(target_vertex),
		.is_positive(is_positive),
		.end_of_group(end_of_group),
		.coord_index(coord_index),
		.coord_value(coord_value),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_kind(q_kind),
		.q_src(q_src),
		.q_tgt(q_tgt),
		.q_positive(q_positive),
		.q_eog(q_eog),
		.q_ci(q_ci),
		.q_value(q_value)
	);

	epgu_back #(
		.VERT_COUNT(VERT_COUNT),
		.DIM(DIM)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_kind(q_kind),
		.q_src(q_src),
		.q_tgt(q_tgt),
		.q_positive(q_positive),
		.q_eog(q_eog),
		.q_ci(q_ci),
		.q_value(q_value),
		.gamma(gamma_q),
		.grad_clip(clip_q),
		.learn_rate(lr_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.coord_out(coord_out),
		.dist_sq(dist_sq),
		.clipped_count(clipped_count)
	);

endmodule

// ----- rtl/epgu_div.sv -----
module epgu_div (
	input logic clk,
	input logic arst_n,
	input epgu_pkg::div_req_t req,
	output epgu_pkg::div_rsp_t rsp
);
	import epgu_pkg::*;

	localparam int STEP_CW = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [STEP_CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_DEN_W:0] rem_sh;
	logic [DIV_DEN_W:0] rem_sub;
	logic fits;

	assign rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
	assign fits = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= STEP_CW'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("Division started while the divider is busy.");

endmodule

// ----- rtl/epgu_front.sv -----
module epgu_front #(
	parameter int VERT_COUNT = epgu_pkg::VERT_COUNT_DEF,
	parameter int DIM = epgu_pkg::DIM_DEF,
	localparam int VW = $clog2(VERT_COUNT),
	localparam int IW = (DIM > 1) ? $clog2(DIM) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [epgu_pkg::REQ_W-1:0] req_type,
	input logic [epgu_pkg::VERT_W-1:0] source_vertex,
	input logic [epgu_pkg::VERT_W-1:0] target_vertex,
	input logic is_positive,
	input logic end_of_group,
	input logic [epgu_pkg::CI_W-1:0] coord_index,
	input logic signed [epgu_pkg::COORD_W-1:0] coord_value,
	output logic q_valid,
	input logic q_pop,
	output epgu_pkg::kind_t q_kind,
	output logic [VW-1:0] q_src,
	output logic [VW-1:0] q_tgt,
	output logic q_positive,
	output logic q_eog,
	output logic [IW-1:0] q_ci,
	output logic [epgu_pkg::COORD_W-1:0] q_value
);
	import epgu_pkg::*;

	localparam int EW = 2 + 2 * VW + 2 + IW + COORD_W;

	logic v_s1;
	logic [REQ_W-1:0] req_s1;
	logic [VERT_W-1:0] src_s1;
	logic [VERT_W-1:0] tgt_s1;
	logic pos_s1;
	logic eog_s1;
	logic [CI_W-1:0] ci_s1;
	logic [COORD_W-1:0] val_s1;

	logic accept;
	logic push;
	logic full;
	logic ci_ok;
	kind_t kind;
	logic [VW-1:0] src_red;
	logic [VW-1:0] tgt_red;

	logic [EW-1:0] fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fifo_cnt_q;
	logic [EW-1:0] head;

	assign full = fifo_cnt_q == 2'd2;
	assign in_stall = v_s1 && full;
	assign accept = in_valid && !in_stall;
	assign push = v_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_type;
			src_s1 <= source_vertex;
			tgt_s1 <= target_vertex;
			pos_s1 <= is_positive;
			eog_s1 <= end_of_group;
			ci_s1 <= coord_index;
			val_s1 <= coord_value;
		end
	end

	if (VERT_COUNT >= (1 << VERT_W)) begin : g_pass
		assign src_red = VW'(src_s1);
		assign tgt_red = VW'(tgt_s1);
	end else begin : g_mod
		localparam int RED_SH = 21;
		localparam int PW = VERT_W + RED_SH;
		localparam int MW = 2 * VERT_W;
		localparam logic [RED_SH-1:0] RECIP = RED_SH'((64'd1 << RED_SH) / VERT_COUNT);
		logic [VERT_W-1:0] qs_s1;
		logic [VERT_W-1:0] qt_s1;
		logic [PW-1:0] ps;
		logic [PW-1:0] pt;
		logic [MW-1:0] rs;
		logic [MW-1:0] rt;
		logic [MW-1:0] rs_c;
		logic [MW-1:0] rt_c;

		assign ps = PW'(source_vertex) * PW'(RECIP);
		assign pt = PW'(target_vertex) * PW'(RECIP);

		always_ff @(posedge clk) begin
			if (accept) begin
				qs_s1 <= ps[PW-1:RED_SH];
				qt_s1 <= pt[PW-1:RED_SH];
			end
		end

		assign rs = MW'(src_s1) - MW'(qs_s1) * MW'(VERT_COUNT);
		assign rt = MW'(tgt_s1) - MW'(qt_s1) * MW'(VERT_COUNT);
		assign rs_c = (rs >= MW'(VERT_COUNT)) ? rs - MW'(VERT_COUNT) : rs;
		assign rt_c = (rt >= MW'(VERT_COUNT)) ? rt - MW'(VERT_COUNT) : rt;
		assign src_red = rs_c[VW-1:0];
		assign tgt_red = rt_c[VW-1:0];
	end

	assign ci_ok = {1'b0, ci_s1} < (CI_W + 1)'(DIM);

	always_comb begin
		unique case (req_s1)
			REQ_UPDATE: kind = KIND_UPD;
			REQ_WRITE: kind = ci_ok ? KIND_WR : KIND_NOP;
			REQ_READ: kind = ci_ok ? KIND_RD : KIND_NOP;
			default: kind = KIND_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= {kind, src_red, tgt_red, pos_s1, eog_s1, ci_s1[IW-1:0], val_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fifo_cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				fifo_cnt_q <= fifo_cnt_q + 2'd1;
			end else if (q_pop && !push) begin
				fifo_cnt_q <= fifo_cnt_q - 2'd1;
			end
		end
	end

	assign head = fifo_q[rd_ptr_q];
	assign q_valid = fifo_cnt_q != 2'd0;
	assign q_kind = kind_t'(head[EW-1:EW-2]);
	assign q_src = head[EW-3:EW-2-VW];
	assign q_tgt = head[EW-3-VW:EW-2-2*VW];
	assign q_positive = head[IW+COORD_W+1];
	assign q_eog = head[IW+COORD_W];
	assign q_ci = head[IW+COORD_W-1:COORD_W];
	assign q_value = head[COORD_W-1:0];

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> fifo_cnt_q != 2'd0)
		else $error("Queue popped while empty.");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q != 2'd3)
		else $error("Queue count beyond its depth.");

endmodule

// ----- rtl/epgu_back.sv -----
module epgu_back #(
	parameter int VERT_COUNT = epgu_pkg::VERT_COUNT_DEF,
	parameter int DIM = epgu_pkg::DIM_DEF,
	localparam int VW = $clog2(VERT_COUNT),
	localparam int IW = (DIM > 1) ? $clog2(DIM) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input epgu_pkg::kind_t q_kind,
	input logic [VW-1:0] q_src,
	input logic [VW-1:0] q_tgt,
	input logic q_positive,
	input logic q_eog,
	input logic [IW-1:0] q_ci,
	input logic [epgu_pkg::COORD_W-1:0] q_value,
	input logic [epgu_pkg::GAMMA_W-1:0] gamma,
	input logic [epgu_pkg::CLIP_W-1:0] grad_clip,
	input logic [epgu_pkg::LR_W-1:0] learn_rate,
	output logic out_valid,
	input logic out_stall,
	output logic signed [epgu_pkg::COORD_W-1:0] coord_out,
	output logic [epgu_pkg::COORD_W-1:0] dist_sq,
	output logic [epgu_pkg::CNT_W-1:0] clipped_count
);
	import epgu_pkg::*;

	localparam int DEPTH = VERT_COUNT * DIM;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DIM + 1);

	function automatic logic [COORD_W-1:0] sat32(input logic [COORD_W+1:0] v);
		if (v[COORD_W+1:COORD_W-1] == 3'b000 || v[COORD_W+1:COORD_W-1] == 3'b111) begin
			return v[COORD_W-1:0];
		end
		return v[COORD_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	bst_t state_q;
	bst_t state_d;

	logic [COORD_W-1:0] mem [DEPTH];
	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [COORD_W-1:0] mem_wdata;
	logic [COORD_W-1:0] mem_rdata_q;

	logic [AW-1:0] src_base_q;
	logic [AW-1:0] tgt_base_q;
	logic pos_q;
	logic eog_q;
	logic [IW-1:0] ci_q;
	logic [COORD_W-1:0] val_q;
	logic [CW-1:0] cnt_q;
	logic [COORD_W-1:0] s_q;
	logic [COORD_W-1:0] t_q [DIM];
	logic [DIFF_W-1:0] d_q [DIM];
	logic [COORD_W-1:0] acc_q [DIM];
	logic [COORD_W-1:0] f_q;
	logic [GMAG_W-1:0] gmag_q;
	logic [CLIP_W-1:0] m_q;
	logic [CNT_W-1:0] clip_cnt_q;
	logic [COORD_W-1:0] coord_q;
	logic [PROD_W-1:0] prod_q;

	logic out_valid_q;
	logic [COORD_W-1:0] coord_out_q;
	logic [COORD_W-1:0] dist_q;
	logic [CNT_W-1:0] clipped_q;

	logic [IW-1:0] idx;
	logic last;
	logic [DIFF_W-1:0] d_cur;
	logic [DIFF_W-1:0] abs_d;
	logic [PROD_W-17:0] prod_hi;
	logic [PROD_W-17:0] f_sum;
	logic [COORD_W-1:0] f_next;
	logic over;
	logic [STEP_W:0] step_v;
	logic [COORD_W+1:0] step34;
	logic [COORD_W+1:0] acc34;
	logic [DIFF_W-1:0] mul_a;
	logic [DIFF_W-1:0] mul_b;
	logic out_load;
	logic out_free;
	div_req_t div_req;
	div_rsp_t div_rsp;

	epgu_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign idx = cnt_q[IW-1:0];
	assign last = cnt_q == CW'(DIM - 1);
	assign d_cur = d_q[idx];
	assign abs_d = d_cur[DIFF_W-1] ? DIFF_W'(0) - d_cur : d_cur;
	assign prod_hi = prod_q[PROD_W-1:16];
	assign f_sum = (PROD_W - 16)'(f_q) + prod_hi;
	assign f_next = (|f_sum[PROD_W-17:COORD_W]) ? '1 : f_sum[COORD_W-1:0];
	assign over = prod_hi > (PROD_W - 16)'(grad_clip);
	assign step_v = (pos_q ^ d_cur[DIFF_W-1]) ?
		(STEP_W + 1)'(0) - {1'b0, prod_q[16+STEP_W-1:16]} : {1'b0, prod_q[16+STEP_W-1:16]};
	assign step34 = {{(COORD_W + 1 - STEP_W){step_v[STEP_W]}}, step_v};
	assign acc34 = {{2{acc_q[idx][COORD_W-1]}}, acc_q[idx]};
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		prod_q <= {{(PROD_W - DIFF_W){1'b0}}, mul_a} * {{(PROD_W - DIFF_W){1'b0}}, mul_b};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_kind)
						KIND_UPD: state_d = ST_LD_S;
						KIND_WR: state_d = ST_WR;
						KIND_RD: state_d = ST_RD;
						default: state_d = ST_RESULT;
					endcase
				end
			end
			ST_WR: state_d = ST_RESULT;
			ST_RD: state_d = ST_RD_DATA;
			ST_RD_DATA: state_d = ST_RESULT;
			ST_LD_S: state_d = ST_LD_T;
			ST_LD_T: state_d = ST_LD_D;
			ST_LD_D: state_d = ST_SQ;
			ST_SQ: state_d = ST_ACC;
			ST_ACC: state_d = last ? ST_DIV1_GO : ST_LD_S;
			ST_DIV1_GO: state_d = ST_DIV1;
			ST_DIV1: begin
				if (div_rsp.done) begin
					state_d = pos_q ? ST_GM1 : ST_DIV2_GO;
				end
			end
			ST_DIV2_GO: state_d = ST_DIV2;
			ST_DIV2: begin
				if (div_rsp.done) begin
					state_d = ST_GM1;
				end
			end
			ST_GM1: state_d = ST_GM2;
			ST_GM2: state_d = ST_GM3;
			ST_GM3: state_d = ST_GM4;
			ST_GM4: begin
				if (!last) begin
					state_d = ST_GM1;
				end else begin
					state_d = eog_q ? ST_CM_RD : ST_RESULT;
				end
			end
			ST_CM_RD: state_d = ST_CM_WR;
			ST_CM_WR: state_d = last ? ST_RESULT : ST_CM_RD;
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		mem_we = 1'b0;
		mem_addr = src_base_q + AW'(idx);
		mem_wdata = val_q;
		mul_a = abs_d;
		mul_b = abs_d;
		div_req = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_WR: begin
				mem_we = 1'b1;
				mem_addr = src_base_q + AW'(ci_q);
			end
			ST_RD: mem_addr = src_base_q + AW'(ci_q);
			ST_LD_T: mem_addr = tgt_base_q + AW'(idx);
			ST_DIV1_GO: begin
				div_req.start = 1'b1;
				div_req.num = pos_q ? {{(DIV_NUM_W - 34){1'b0}}, 1'b1, 33'b0} :
					{{(DIV_NUM_W - GAMMA_W - 33){1'b0}}, gamma, 33'b0};
				div_req.den = DIV_DEN_W'(f_q) + DIV_DEN_W'(ONE_Q);
			end
			ST_DIV2_GO: begin
				div_req.start = 1'b1;
				div_req.num = div_rsp.quo;
				div_req.den = DIV_DEN_W'(f_q) + DIV_DEN_W'(TENTH_Q);
			end
			ST_GM1: mul_a = DIFF_W'(gmag_q);
			ST_GM3: begin
				mul_a = DIFF_W'(m_q);
				mul_b = DIFF_W'(learn_rate);
			end
			ST_GM4: begin
				mem_we = 1'b1;
				mem_addr = tgt_base_q + AW'(idx);
				mem_wdata = sat32({{2{t_q[idx][COORD_W-1]}}, t_q[idx]} - step34);
			end
			ST_CM_WR: begin
				mem_we = 1'b1;
				mem_wdata = sat32({{2{mem_rdata_q[COORD_W-1]}}, mem_rdata_q} + acc34);
			end
			ST_RESULT: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIM; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: cnt_q <= '0;
				ST_ACC: cnt_q <= last ? '0 : cnt_q + 1'b1;
				ST_GM4: begin
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					acc_q[idx] <= sat32(acc34 + step34);
				end
				ST_CM_WR: begin
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					acc_q[idx] <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					src_base_q <= AW'(q_src) * AW'(DIM);
					tgt_base_q <= AW'(q_tgt) * AW'(DIM);
					pos_q <= q_positive;
					eog_q <= q_eog;
					ci_q <= q_ci;
					val_q <= q_value;
					f_q <= '0;
					clip_cnt_q <= '0;
					coord_q <= '0;
				end
			end
			ST_RD_DATA: coord_q <= mem_rdata_q;
			ST_LD_T: s_q <= mem_rdata_q;
			ST_LD_D: begin
				t_q[idx] <= mem_rdata_q;
				d_q[idx] <= {s_q[COORD_W-1], s_q} - {mem_rdata_q[COORD_W-1], mem_rdata_q};
			end
			ST_ACC: f_q <= f_next;
			ST_DIV1: begin
				if (div_rsp.done && pos_q) begin
					gmag_q <= div_rsp.quo[GMAG_W-1:0];
				end
			end
			ST_DIV2: begin
				if (div_rsp.done) begin
					gmag_q <= div_rsp.quo[GMAG_W-1:0];
				end
			end
			ST_GM2: begin
				if (over) begin
					m_q <= grad_clip;
					clip_cnt_q <= clip_cnt_q + 1'b1;
				end else begin
					m_q <= prod_hi[CLIP_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			coord_out_q <= coord_q;
			dist_q <= f_q;
			clipped_q <= clip_cnt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign coord_out = coord_out_q;
	assign dist_sq = dist_q;
	assign clipped_count = clipped_q;

	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> clipped_q <= CNT_W'(DIM))
		else $error("Clipped count exceeds the coordinate count.");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CW'(DIM))
		else $error("Coordinate counter out of range.");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && !out_valid_q) |=> out_valid_q && state_q == ST_IDLE)
		else $error("Finished transaction not presented at the output.");

endmodule

// ----- tb/epgu_checker.sv -----
module epgu_checker (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [epgu_pkg::PADDR_W-1:0] paddr,
	input logic [epgu_pkg::PDATA_W-1:0] pwdata,
	input logic pready,
	input logic in_valid,
	input logic in_stall,
	input logic [epgu_pkg::REQ_W-1:0] req_type,
	input logic [epgu_pkg::VERT_W-1:0] source_vertex,
	input logic [epgu_pkg::VERT_W-1:0] target_vertex,
	input logic is_positive,
	input logic end_of_group,
	input logic [epgu_pkg::CI_W-1:0] coord_index,
	input logic signed [epgu_pkg::COORD_W-1:0] coord_value,
	input logic out_valid,
	input logic out_stall,
	input logic signed [epgu_pkg::COORD_W-1:0] coord_out,
	input logic [epgu_pkg::COORD_W-1:0] dist_sq,
	input logic [epgu_pkg::CNT_W-1:0] clipped_count,
	output int fails,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import epgu_pkg::*;

	localparam int NV = VERT_COUNT_DEF;
	localparam int D = DIM_DEF;

	typedef struct packed {
		logic [COORD_W-1:0] coord;
		logic [COORD_W-1:0] dsq;
		logic [CNT_W-1:0] cnt;
	} grad_result_t;

	logic signed [COORD_W-1:0] coord_mem [NV*D];
	logic signed [COORD_W-1:0] err_acc [D];
	logic [GAMMA_W-1:0] gamma_q;
	logic [CLIP_W-1:0] clip_q;
	logic [LR_W-1:0] lr_q;
	grad_result_t expected_q [$];

	function automatic logic signed [COORD_W-1:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	function automatic grad_result_t compute_step(logic [REQ_W-1:0] rq, int sv, int tv,
			logic pos, logic eog, int ci, logic signed [31:0] val);
		grad_result_t r;
		int sb;
		int tb;
		longint dd [D];
		longint unsigned a;
		longint unsigned f;
		longint unsigned d1;
		longint unsigned gmag;
		longint unsigned m;
		longint st;
		logic neg;
		r = '0;
		sb = (sv % NV) * D;
		tb = (tv % NV) * D;
		if (rq == REQ_WRITE) begin
			if (ci < D) coord_mem[sb+ci] = val;
		end else if (rq == REQ_READ) begin
			if (ci < D) r.coord = coord_mem[sb+ci];
		end else if (rq == REQ_UPDATE) begin
			f = 0;
			for (int i = 0; i < D; i++) begin
				dd[i] = longint'(coord_mem[sb+i]) - longint'(coord_mem[tb+i]);
				a = dd[i] < 0 ? longint'(-dd[i]) : dd[i];
				f += (a * a) >> 16;
				if (f > 64'hffffffff) f = 64'hffffffff;
			end
			r.dsq = f[31:0];
			d1 = 64'd65536 + f;
			if (pos) gmag = (64'd1 << 33) / d1;
			else gmag = (((64'd2 * gamma_q) << 32) / d1) / (64'd6554 + f);
			for (int i = 0; i < D; i++) begin
				a = dd[i] < 0 ? longint'(-dd[i]) : dd[i];
				m = (gmag * a) >> 16;
				neg = pos != (dd[i] < 0);
				if (m > clip_q) begin
					m = clip_q;
					r.cnt++;
				end
				st = longint'((m * lr_q) >> 16);
				if (neg) st = -st;
				coord_mem[tb+i] = sat32(longint'(coord_mem[tb+i]) - st);
				err_acc[i] = sat32(longint'(err_acc[i]) + st);
			end
			if (eog) begin
				for (int i = 0; i < D; i++) begin
					coord_mem[sb+i] = sat32(longint'(coord_mem[sb+i]) + longint'(err_acc[i]));
					err_acc[i] = 0;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grad_result_t w;
		if (!arst_n) begin
			gamma_q = GAMMA_RST;
			clip_q = CLIP_RST;
			lr_q = LR_RST;
			for (int i = 0; i < D; i++) err_acc[i] = 0;
			for (int i = 0; i < NV*D; i++) coord_mem[i] = 0;
			expected_q.delete();
			fails = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_GAMMA: gamma_q = pwdata[GAMMA_W-1:0];
					REG_CLIP: clip_q = pwdata[CLIP_W-1:0];
					REG_LR: lr_q = pwdata[LR_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected transaction", coord_out, 0);
				end else begin
					w = expected_q.pop_front();
					if (coord_out !== w.coord) report("coord_out", coord_out, w.coord);
					if (dist_sq !== w.dsq) report("dist_sq", dist_sq, w.dsq);
					if (clipped_count !== w.cnt) report("clipped_count", clipped_count, w.cnt);
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(compute_step(req_type, source_vertex, target_vertex,
					is_positive, end_of_group, coord_index, coord_value));
		end
		pending = expected_q.size();
	end
endmodule

// ----- tb/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import epgu_pkg::*;

	localparam int D = DIM_DEF;
	localparam int NV = VERT_COUNT_DEF;
	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [REQ_W-1:0] req_type = '0;
	logic [VERT_W-1:0] source_vertex = '0, target_vertex = '0;
	logic is_positive = 0, end_of_group = 0;
	logic [CI_W-1:0] coord_index = '0;
	logic signed [COORD_W-1:0] coord_value = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [COORD_W-1:0] coord_out;
	logic [COORD_W-1:0] dist_sq;
	logic [CNT_W-1:0] clipped_count;
	int fails, pending;
	int send_idle = 0, stall_pct = 0;
	int quiet = 0;
	bit written [NV*D];
	bit ready [NV];
	int ready_q [$];

	embedding_pair_gradient_update dut (.*);
	epgu_checker chk (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(negedge clk) out_stall = ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
		else quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		psel = 1;
		pwrite = 1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic drain();
		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	task automatic set_regs(logic [31:0] g, logic [31:0] c, logic [31:0] l);
		drain();
		apb_write(REG_GAMMA, g);
		apb_write(REG_CLIP, c);
		apb_write(REG_LR, l);
	endtask

	task automatic send(logic [1:0] rq, int sv, int tv, logic pos, logic eog, int ci,
			logic [31:0] val);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid = 0;
			@(negedge clk);
		end
		req_type = rq;
		source_vertex = VERT_W'(sv);
		target_vertex = VERT_W'(tv);
		is_positive = pos;
		end_of_group = eog;
		coord_index = CI_W'(ci);
		coord_value = val;
		in_valid = 1;
		do @(posedge clk); while (!(in_valid && !in_stall));
		@(negedge clk);
		if (rq == REQ_WRITE && ci < D) begin
			written[sv*D+ci] = 1;
			if (!ready[sv] && written[sv*D] && written[sv*D+1]) begin
				ready[sv] = 1;
				ready_q.push_back(sv);
			end
		end
	endtask

	function automatic logic [31:0] rand_coord();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80) return $urandom_range(0, 393216) - 196608;
		if (p < 90) return $urandom;
		return p[0] ? 32'h7fffffff : 32'h80000000;
	endfunction

	task automatic random_phase(int n);
		int p, sv, tv, ci;
		for (int k = 0; k < n; k++) begin
			if (k == n / 2) drain();
			p = $urandom_range(0, 99);
			if (p < 15) begin
				send(REQ_WRITE, $urandom_range(0, NV-1), $urandom_range(0, NV-1),
					$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 7),
					rand_coord());
			end else if (p < 25) begin
				ci = $urandom_range(0, 7);
				sv = ready_q[$urandom_range(0, ready_q.size()-1)];
				if (ci >= D) sv = $urandom_range(0, NV-1);
				send(REQ_READ, sv, $urandom_range(0, NV-1), $urandom_range(0, 1),
					$urandom_range(0, 1), ci, $urandom);
			end else if (p < 30) begin
				send(2'd3, $urandom_range(0, NV-1), $urandom_range(0, NV-1),
					$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 7),
					$urandom);
			end else begin
				sv = ready_q[$urandom_range(0, ready_q.size()-1)];
				tv = ($urandom_range(0, 9) == 0) ? sv :
					ready_q[$urandom_range(0, ready_q.size()-1)];
				send(REQ_UPDATE, sv, tv, $urandom_range(0, 1),
					($urandom_range(0, 3) == 0), $urandom_range(0, 7), $urandom);
			end
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send(REQ_WRITE, 0, 0, 1, 1, 0, 32'sh7fffffff);
		send(REQ_WRITE, 0, 0, 0, 0, 1, 32'sh80000000);
		send(REQ_WRITE, 1023, 1023, 0, 0, 0, 32'sh80000000);
		send(REQ_WRITE, 1023, 1023, 1, 1, 1, 32'sh7fffffff);
		send(REQ_WRITE, 1023, 0, 0, 0, 7, 32'h12345678);
		send(REQ_READ, 1023, 0, 1, 1, 0, 0);
		send(REQ_READ, 0, 0, 0, 0, 1, 0);
		send(REQ_READ, 5, 0, 0, 0, 7, 0);
		send(2'd3, 1023, 1023, 1, 1, 7, 32'hffffffff);
		send(REQ_UPDATE, 0, 1023, 1, 0, 0, 0);
		send(REQ_UPDATE, 1023, 0, 0, 1, 0, 0);
		send(REQ_UPDATE, 0, 0, 1, 1, 0, 0);
		send(REQ_WRITE, 1, 0, 0, 0, 0, 32'sh00010000);
		send(REQ_WRITE, 1, 0, 0, 0, 1, 32'sh00008000);
		send(REQ_WRITE, 2, 0, 0, 0, 0, 32'shffff0000);
		send(REQ_WRITE, 2, 0, 0, 0, 1, 32'sh00000000);
		send(REQ_UPDATE, 1, 2, 1, 0, 0, 0);
		send(REQ_UPDATE, 1, 2, 0, 0, 0, 0);
		send(REQ_UPDATE, 2, 2, 0, 1, 0, 0);
		send(REQ_UPDATE, 1, 2, 0, 1, 0, 0);
		send(REQ_READ, 1, 0, 0, 0, 0, 0);
		send(REQ_READ, 2, 0, 0, 0, 1, 0);
		for (int v = 0; v < 12; v++) begin
			send(REQ_WRITE, $urandom_range(0, NV-1), 0, 0, 0, 0, rand_coord());
		end
		for (int v = 0; v < 16; v++) begin
			send(REQ_WRITE, 3 + v, 0, 0, 0, 0, rand_coord());
			send(REQ_WRITE, 3 + v, 0, 0, 0, 1, rand_coord());
		end
		set_regs(32'hffffff, 32'hffffff, 32'd131072);
		random_phase(200);
		set_regs(0, 0, 0);
		send_idle = 70;
		random_phase(200);
		set_regs($urandom_range(0, 1048576), $urandom_range(0, 262144),
			$urandom_range(0, 131072));
		send_idle = 0;
		stall_pct = 70;
		random_phase(200);
		set_regs(GAMMA_RST, 32'd8192, 32'd16384);
		send_idle = 18;
		stall_pct = 18;
		random_phase(200);
		set_regs(32'd65536, CLIP_RST, LR_RST);
		send_idle = 0;
		stall_pct = 0;
		random_phase(200);
		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
